FILE: rtl/nearest_prototype_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest prototype classifier
// Clocked assertion helpers used by the top RTL file of this block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PROTOTYPE_CLASSIFIER_UNIT_MACROS_SVH
`define NEAREST_PROTOTYPE_CLASSIFIER_UNIT_MACROS_SVH

// Assertion on an explicit clock and reset.
`define NPC_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("npc assertion failed");

// Assertion on the block clock and reset.
`define NPC_ASSERT(lbl, prop) `NPC_ASSERT_CLK(lbl, clock, reset, prop)

`endif

FILE: rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Types and constants shared by the nearest prototype classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

   localparam int NUM_PROTO   = 4;
   localparam int PROTO_W     = 50;
   localparam int IDX_W       = 2;
   localparam int DATA_W      = 24;
   localparam int STAMP_W     = 32;
   localparam int COORD_W     = 16;
   localparam int DIST_W      = 35;
   localparam int DEN_W       = 36;
   localparam int CONF_W      = 16;
   localparam int LABEL_W     = 2;

   localparam logic [COORD_W-1:0] FEAT_MAX = 16'd24576;
   localparam logic [DATA_W-1:0]  ONE_Q816 = 24'd65536;
   localparam logic [DEN_W-1:0]   EPS_Q428 = 36'd26844;
   localparam logic [CONF_W-1:0]  CONF_LO  = 16'd32768;
   localparam logic [CONF_W-1:0]  CONF_HI  = 16'd64881;

   // Reciprocals for the energy (divide by 6) and peak (divide by 14) features.
   localparam logic [17:0] RECIP_6   = 18'd174763;
   localparam logic [18:0] RECIP_14  = 19'd299594;
   localparam logic [23:0] LIMIT_6   = 24'd147456;
   localparam logic [23:0] LIMIT_14  = 24'd344064;

   localparam logic [PROTO_W-1:0] PROTO_RESET [NUM_PROTO] = '{
      50'd0, 50'd287105721762775, 50'd615727102105190, 50'd858499806411981
   };

   localparam int DIV_STEPS  = CONF_W;
   localparam int PIPE_DEPTH = 1 + 2 * NUM_PROTO + 1 + DIV_STEPS;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] x2;
   } feat_type;

   typedef struct packed {
      logic [DIST_W-1:0]  best;
      logic [DIST_W-1:0]  second;
      logic [LABEL_W-1:0] label;
   } rank_type;

   typedef struct packed {
      logic [DEN_W-1:0]   den;
      logic [DEN_W-1:0]   rem;
      logic [CONF_W-1:0]  quo;
      logic [LABEL_W-1:0] label;
   } div_type;

   typedef struct packed {
      logic [DATA_W-1:0]  energy;
      logic [DATA_W-1:0]  max_abs;
      logic [STAMP_W-1:0] stamp;
   } pass_type;

endpackage

`default_nettype wire

FILE: rtl/nearest_prototype_classifier_unit.sv
// Throughput: one word per cycle; the pipeline is a feature stage, four
// two-stage prototype cells, a denominator stage and sixteen divider cells.
// The whole pipeline holds while a result word waits under rsp_stall.
// Reset (synchronous) empties the pipeline and loads the default prototypes.
// ----------------------------------------------------------------------------
// nearest_prototype_classifier_unit
// Nearest prototype motion classifier with separation confidence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_prototype_classifier_unit_macros.svh"

module nearest_prototype_classifier_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [npc_pkg::DATA_W-1:0]    req_var_x,
   input  wire logic [npc_pkg::DATA_W-1:0]    req_var_y,
   input  wire logic [npc_pkg::DATA_W-1:0]    req_var_z,
   input  wire logic [npc_pkg::DATA_W-1:0]    req_energy_in,
   input  wire logic [npc_pkg::DATA_W-1:0]    req_max_abs_in,
   input  wire logic [npc_pkg::STAMP_W-1:0]   req_time_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [npc_pkg::LABEL_W-1:0]        rsp_motion_class,
   output logic [npc_pkg::CONF_W-1:0]         rsp_confidence_out,
   output logic [npc_pkg::DATA_W-1:0]         rsp_energy_out,
   output logic [npc_pkg::DATA_W-1:0]         rsp_max_abs_out,
   output logic [npc_pkg::STAMP_W-1:0]        rsp_stamp_out,
   input  wire logic                          csr_write,
   input  wire logic [npc_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [npc_pkg::PROTO_W-1:0]   csr_data
);
   import npc_pkg::*;

   localparam int PROTO_END = 2 * NUM_PROTO;
   localparam int DEN_STAGE = PROTO_END + 1;

   logic                  advance;
   logic [PROTO_W-1:0]    proto_ff [NUM_PROTO];
   logic [PIPE_DEPTH-1:0] vld_ff;
   pass_type              pass_ff [PIPE_DEPTH];
   feat_type              feat_w [NUM_PROTO+1];
   rank_type              rank_w [NUM_PROTO+1];
   div_type               div_w [DIV_STEPS+1];
   div_type               den_in;
   div_type               den_ff;
   logic [CONF_W-1:0]     conf_in;
   logic                  rsp_valid_ff;
   logic [LABEL_W-1:0]    class_ff;
   logic [CONF_W-1:0]     conf_ff;
   pass_type              rsp_pass_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PROTO; i++) begin
            proto_ff[i] <= PROTO_RESET[i];
         end
      end else if (csr_write) begin
         proto_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pass_ff[0] <= '{energy: req_energy_in, max_abs: req_max_abs_in, stamp: req_time_ms};
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            pass_ff[k] <= pass_ff[k-1];
         end
      end
   end

   npc_feature u_feature (
      .clock   (clock),
      .enable  (advance),
      .var_x   (req_var_x),
      .var_y   (req_var_y),
      .var_z   (req_var_z),
      .energy  (req_energy_in),
      .max_abs (req_max_abs_in),
      .feat    (feat_w[0])
   );

   assign rank_w[0] = '{best: '1, second: '1, label: '0};

   for (genvar g = 0; g < NUM_PROTO; g++) begin : g_proto
      npc_proto_cell u_cell (
         .clock  (clock),
         .enable (advance),
         .proto  (proto_ff[g]),
         .feat_i (feat_w[g]),
         .rank_i (rank_w[g]),
         .feat_o (feat_w[g+1]),
         .rank_o (rank_w[g+1])
      );
   end

   always_comb begin
      den_in.den   = DEN_W'(rank_w[NUM_PROTO].best) + DEN_W'(rank_w[NUM_PROTO].second)
                     + EPS_Q428;
      den_in.rem   = DEN_W'(rank_w[NUM_PROTO].second);
      den_in.quo   = '0;
      den_in.label = rank_w[NUM_PROTO].label;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff <= den_in;
      end
   end

   assign div_w[0] = den_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      npc_div_cell u_cell (
         .clock  (clock),
         .enable (advance),
         .div_i  (div_w[g]),
         .div_o  (div_w[g+1])
      );
   end

   always_comb begin
      if (div_w[DIV_STEPS].quo < CONF_LO) begin
         conf_in = CONF_LO;
      end else if (div_w[DIV_STEPS].quo > CONF_HI) begin
         conf_in = CONF_HI;
      end else begin
         conf_in = div_w[DIV_STEPS].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         class_ff    <= div_w[DIV_STEPS].label;
         conf_ff     <= conf_in;
         rsp_pass_ff <= pass_ff[PIPE_DEPTH-1];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motion_class   = class_ff;
   assign rsp_confidence_out = conf_ff;
   assign rsp_energy_out     = rsp_pass_ff.energy;
   assign rsp_max_abs_out    = rsp_pass_ff.max_abs;
   assign rsp_stamp_out      = rsp_pass_ff.stamp;

   `NPC_ASSERT(a_last_to_rsp, (advance && vld_ff[PIPE_DEPTH-1]) |=> rsp_valid_ff)
   `NPC_ASSERT(a_hold_pipe, !advance |=> $stable(vld_ff))
   `NPC_ASSERT(a_rank_order, vld_ff[PROTO_END] |-> (rank_w[NUM_PROTO].best <= rank_w[NUM_PROTO].second))
   `NPC_ASSERT(a_den_bound, vld_ff[DEN_STAGE] |-> (den_ff.rem < den_ff.den))

endmodule

`default_nettype wire

FILE: rtl/npc_feature.sv
// ----------------------------------------------------------------------------
// npc_feature
// Builds the registered Q2.14 feature vector from one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_feature (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [npc_pkg::DATA_W-1:0]    var_x,
   input  wire logic [npc_pkg::DATA_W-1:0]    var_y,
   input  wire logic [npc_pkg::DATA_W-1:0]    var_z,
   input  wire logic [npc_pkg::DATA_W-1:0]    energy,
   input  wire logic [npc_pkg::DATA_W-1:0]    max_abs,
   output npc_pkg::feat_type                  feat
);
   import npc_pkg::*;

   logic [25:0] sum;
   logic [28:0] scaled;
   logic [24:0] x0_raw;
   logic [23:0] e_ofs;
   logic [23:0] m_ofs;
   logic [35:0] e_prod;
   logic [37:0] m_prod;
   feat_type    feat_in;
   feat_type    feat_ff;

   always_comb begin
      sum    = 26'(var_x) + 26'(var_y) + 26'(var_z);
      scaled = (29'(sum) << 2) + 29'(sum) + 29'd8;
      x0_raw = scaled[28:4];
      feat_in.x0 = (x0_raw > 25'(FEAT_MAX)) ? FEAT_MAX : x0_raw[COORD_W-1:0];

      e_ofs  = energy - ONE_Q816 + 24'd3;
      e_prod = 36'(e_ofs[17:0]) * 36'(RECIP_6);
      if (energy <= ONE_Q816) begin
         feat_in.x1 = '0;
      end else if (e_ofs >= LIMIT_6) begin
         feat_in.x1 = FEAT_MAX;
      end else begin
         feat_in.x1 = e_prod[35:20];
      end

      m_ofs  = max_abs - ONE_Q816 + 24'd7;
      m_prod = 38'(m_ofs[18:0]) * 38'(RECIP_14);
      if (max_abs <= ONE_Q816) begin
         feat_in.x2 = '0;
      end else if (m_ofs >= LIMIT_14) begin
         feat_in.x2 = FEAT_MAX;
      end else begin
         feat_in.x2 = m_prod[37:22];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         feat_ff <= feat_in;
      end
   end

   assign feat = feat_ff;

endmodule

`default_nettype wire

FILE: rtl/npc_proto_cell.sv
// ----------------------------------------------------------------------------
// npc_proto_cell
// Weighted distance to one prototype and running best/second ranking.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_proto_cell (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [npc_pkg::PROTO_W-1:0]   proto,
   input  wire npc_pkg::feat_type             feat_i,
   input  wire npc_pkg::rank_type             rank_i,
   output npc_pkg::feat_type                  feat_o,
   output npc_pkg::rank_type                  rank_o
);
   import npc_pkg::*;

   logic [COORD_W-1:0] d0, d1, d2;
   logic [31:0]        sq0_ff, sq1_ff, sq2_ff;
   feat_type           feat_mid_ff;
   rank_type           rank_mid_ff;
   logic [DIST_W-1:0]  dist_sum;
   feat_type           feat_ff;
   rank_type           rank_in;
   rank_type           rank_ff;

   always_comb begin
      d0 = (feat_i.x0 >= proto[47:32]) ? feat_i.x0 - proto[47:32] : proto[47:32] - feat_i.x0;
      d1 = (feat_i.x1 >= proto[31:16]) ? feat_i.x1 - proto[31:16] : proto[31:16] - feat_i.x1;
      d2 = (feat_i.x2 >= proto[15:0])  ? feat_i.x2 - proto[15:0]  : proto[15:0] - feat_i.x2;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq0_ff      <= 32'(d0) * 32'(d0);
         sq1_ff      <= 32'(d1) * 32'(d1);
         sq2_ff      <= 32'(d2) * 32'(d2);
         feat_mid_ff <= feat_i;
         rank_mid_ff <= rank_i;
      end
   end

   always_comb begin
      dist_sum = DIST_W'(sq0_ff) + DIST_W'(sq1_ff) + (DIST_W'(sq2_ff) << 1);
      rank_in  = rank_mid_ff;
      if (dist_sum < rank_mid_ff.best) begin
         rank_in.second = rank_mid_ff.best;
         rank_in.best   = dist_sum;
         rank_in.label  = proto[49:48];
      end else if (dist_sum < rank_mid_ff.second) begin
         rank_in.second = dist_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         feat_ff <= feat_mid_ff;
         rank_ff <= rank_in;
      end
   end

   assign feat_o = feat_ff;
   assign rank_o = rank_ff;

endmodule

`default_nettype wire

FILE: rtl/npc_div_cell.sv
// ----------------------------------------------------------------------------
// npc_div_cell
// One restoring-division step of the confidence quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_div_cell (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire npc_pkg::div_type div_i,
   output npc_pkg::div_type      div_o
);
   import npc_pkg::*;

   logic [DEN_W:0] twice;
   div_type        div_in;
   div_type        div_ff;

   always_comb begin
      twice  = {div_i.rem, 1'b0};
      div_in = div_i;
      if (twice >= {1'b0, div_i.den}) begin
         div_in.rem = DEN_W'(twice - {1'b0, div_i.den});
         div_in.quo = {div_i.quo[CONF_W-2:0], 1'b1};
      end else begin
         div_in.rem = twice[DEN_W-1:0];
         div_in.quo = {div_i.quo[CONF_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_ff <= div_in;
      end
   end

   assign div_o = div_ff;

endmodule

`default_nettype wire

FILE: sim/nearest_prototype_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// nearest_prototype_classifier_unit_tb
// Self-checking bench for the nearest prototype classifier. A directed table
// and weighted random feature windows are sent, the random ones mostly under
// random idling on both sides; each result word is compared field by field with
// a bit-exact prediction from the block's prototypes or a typed table row.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_prototype_classifier_unit_tb;

   import npc_pkg::*;

   localparam int PERIOD     = 12;
   localparam int DRAIN_WAIT = PIPE_DEPTH + 8;
   localparam int RAND_WORDS = 1650;
   localparam int PHASES     = 6;

   typedef struct {
      logic [DATA_W-1:0]  var_x;
      logic [DATA_W-1:0]  var_y;
      logic [DATA_W-1:0]  var_z;
      logic [DATA_W-1:0]  energy;
      logic [DATA_W-1:0]  max_abs;
      logic [STAMP_W-1:0] stamp;
   } window_type;

   typedef struct {
      logic [LABEL_W-1:0] motion_class;
      logic [CONF_W-1:0]  confidence;
      logic [DATA_W-1:0]  energy;
      logic [DATA_W-1:0]  max_abs;
      logic [STAMP_W-1:0] stamp;
   } verdict_type;

   typedef struct {
      window_type         w;
      bit                 typed;
      logic [LABEL_W-1:0] motion_class;
      logic [CONF_W-1:0]  confidence;
   } table_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [DATA_W-1:0]  req_var_x, req_var_y, req_var_z, req_energy_in, req_max_abs_in;
   logic [STAMP_W-1:0] req_time_ms;
   logic rsp_valid;
   logic rsp_stall;
   logic [LABEL_W-1:0] rsp_motion_class;
   logic [CONF_W-1:0]  rsp_confidence_out;
   logic [DATA_W-1:0]  rsp_energy_out, rsp_max_abs_out;
   logic [STAMP_W-1:0] rsp_stamp_out;
   logic               csr_write;
   logic [IDX_W-1:0]   csr_index;
   logic [PROTO_W-1:0] csr_data;

   logic [PROTO_W-1:0] prototypes [NUM_PROTO];
   verdict_type        pending_verdicts [$];
   table_row_type      directed_rows [$];
   int unsigned        mismatches;
   int unsigned        words_sent;
   int unsigned        words_checked;
   int unsigned        settings_used;
   bit                 idle_enable;
   int unsigned        stall_left;

   nearest_prototype_classifier_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_var_x(req_var_x), .req_var_y(req_var_y), .req_var_z(req_var_z),
      .req_energy_in(req_energy_in), .req_max_abs_in(req_max_abs_in),
      .req_time_ms(req_time_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_motion_class(rsp_motion_class), .rsp_confidence_out(rsp_confidence_out),
      .rsp_energy_out(rsp_energy_out), .rsp_max_abs_out(rsp_max_abs_out),
      .rsp_stamp_out(rsp_stamp_out),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(PERIOD * 600000);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [COORD_W-1:0] clamp_feature(longint unsigned v);
      return (v > FEAT_MAX) ? FEAT_MAX : COORD_W'(v);
   endfunction

   function automatic logic [COORD_W-1:0] excess_over_one(logic [DATA_W-1:0] v,
                                                          int unsigned div);
      if (v <= ONE_Q816) begin
         return '0;
      end
      return clamp_feature((longint'(v) - ONE_Q816 + div / 2) / div);
   endfunction

   function automatic longint unsigned square_gap(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
      longint unsigned d;
      d = (a >= b) ? longint'(a - b) : longint'(b - a);
      return d * d;
   endfunction

   function automatic verdict_type classify_window(window_type w);
      verdict_type        v;
      longint unsigned    vsum, gap_sum, best, second, conf;
      logic [COORD_W-1:0] f0, f1, f2;
      logic [PROTO_W-1:0] p;
      vsum   = longint'(w.var_x) + longint'(w.var_y) + longint'(w.var_z);
      f0     = clamp_feature((vsum * 5 + 8) >> 4);
      f1     = excess_over_one(w.energy, 6);
      f2     = excess_over_one(w.max_abs, 14);
      best   = '1;
      second = '1;
      v.motion_class = '0;
      for (int i = 0; i < NUM_PROTO; i++) begin
         p       = prototypes[i];
         gap_sum = square_gap(f0, p[47:32]) + square_gap(f1, p[31:16])
                 + 2 * square_gap(f2, p[15:0]);
         if (gap_sum < best) begin
            second = best;
            best   = gap_sum;
            v.motion_class = p[49:48];
         end else if (gap_sum < second) begin
            second = gap_sum;
         end
      end
      conf = (second << 16) / (best + second + EPS_Q428);
      if (conf < CONF_LO) conf = CONF_LO;
      if (conf > CONF_HI) conf = CONF_HI;
      v.confidence = CONF_W'(conf);
      v.energy     = w.energy;
      v.max_abs    = w.max_abs;
      v.stamp      = w.stamp;
      return v;
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] wide_field();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Most windows land in the range where the prototypes live; the rest are
   // full-range noise and saturating corners.
   function automatic window_type random_window();
      window_type w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         w.var_x   = DATA_W'($urandom_range(0, 30000));
         w.var_y   = DATA_W'($urandom_range(0, 30000));
         w.var_z   = DATA_W'($urandom_range(0, 30000));
         w.energy  = DATA_W'($urandom_range(40000, 65536 + 6 * 26000));
         w.max_abs = DATA_W'($urandom_range(40000, 65536 + 14 * 26000));
      end else begin
         w.var_x   = wide_field();
         w.var_y   = wide_field();
         w.var_z   = wide_field();
         w.energy  = wide_field();
         w.max_abs = wide_field();
      end
      w.stamp = $urandom;
      return w;
   endfunction

   function automatic logic [PROTO_W-1:0] random_prototype();
      logic [PROTO_W-1:0] p;
      p[49:48] = 2'($urandom_range(0, 3));
      for (int c = 0; c < 3; c++) begin
         p[c*16 +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 24576));
      end
      return p;
   endfunction

   always @(negedge clock) begin
      if (reset || !idle_enable) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= idle_length();
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked <= words_checked + 1;
         if (pending_verdicts.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_motion_class !== want.motion_class
                || rsp_confidence_out !== want.confidence
                || rsp_energy_out !== want.energy || rsp_max_abs_out !== want.max_abs
                || rsp_stamp_out !== want.stamp) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("mismatch: class %0d/%0d conf %0d/%0d energy %h/%h",
                           want.motion_class, rsp_motion_class, want.confidence,
                           rsp_confidence_out, want.energy, rsp_energy_out);
                  $display("          peak %h/%h stamp %h/%h",
                           want.max_abs, rsp_max_abs_out, want.stamp, rsp_stamp_out);
               end
            end
         end
      end
   end

   task automatic send_window(window_type w, verdict_type want);
      int unsigned gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_var_x      <= w.var_x;
      req_var_y      <= w.var_y;
      req_var_z      <= w.var_z;
      req_energy_in  <= w.energy;
      req_max_abs_in <= w.max_abs;
      req_time_ms    <= w.stamp;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(want);
      words_sent++;
      gap = idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_prototype(int idx, logic [PROTO_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= IDX_W'(idx);
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      prototypes[idx] = value;
   endtask

   task automatic add_row(logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy,
                          logic [DATA_W-1:0] vz, logic [DATA_W-1:0] en,
                          logic [DATA_W-1:0] mx, logic [STAMP_W-1:0] ts,
                          bit typed, logic [LABEL_W-1:0] cls, logic [CONF_W-1:0] conf);
      table_row_type r;
      r.w = '{vx, vy, vz, en, mx, ts};
      r.typed = typed;
      r.motion_class = cls;
      r.confidence = conf;
      directed_rows.push_back(r);
   endtask

   task automatic run_table();
      verdict_type want;
      foreach (directed_rows[i]) begin
         want = classify_window(directed_rows[i].w);
         if (directed_rows[i].typed) begin
            want.motion_class = directed_rows[i].motion_class;
            want.confidence   = directed_rows[i].confidence;
         end
         send_window(directed_rows[i].w, want);
      end
      directed_rows.delete();
   endtask

   initial begin
      window_type w;
      logic [PROTO_W-1:0] same;
      mismatches    = 0;
      words_sent    = 0;
      words_checked = 0;
      settings_used = 1;
      idle_enable   = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_var_x     = '0;
      req_var_y     = '0;
      req_var_z     = '0;
      req_energy_in = '0;
      req_max_abs_in = '0;
      req_time_ms   = '0;
      rsp_stall     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      for (int i = 0; i < NUM_PROTO; i++) prototypes[i] = PROTO_RESET[i];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default prototypes: zero window sits on the still prototype.
      add_row(0, 0, 0, 0, 0, 0, 1, 2'd0, CONF_HI);
      add_row('1, '1, '1, '1, '1, '1, 0, 0, 0);
      add_row(0, 0, 0, ONE_Q816, ONE_Q816, 32'h0000_0001, 1, 2'd0, CONF_HI);
      add_row(0, 0, 0, ONE_Q816 + 1, ONE_Q816 + 1, 32'h8000_0000, 0, 0, 0);
      add_row(78643, 0, 0, 0, 0, 32'hffff_fffe, 0, 0, 0);
      add_row(78642, 1, 0, 0, 0, 32'h1234_5678, 0, 0, 0);
      add_row(1400, 1400, 1395, 65536 + 6 * 655, 65536 + 14 * 983, 7, 0, 0, 0);
      add_row(13000, 13000, 13321, 65536 + 6 * 9011, 65536 + 14 * 5734, 8, 0, 0, 0);
      add_row(3500, 3500, 3486, 65536 + 6 * 4096, 65536 + 14 * 15565, 9, 0, 0, 0);
      add_row(24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
              32'h5555_aaaa, 0, 0, 0);
      add_row(24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
              32'haaaa_5555, 0, 0, 0);
      run_table();
      drain();

      // Identical prototypes tie everywhere: first one wins, floor confidence.
      same = {2'd2, 16'd4000, 16'd3000, 16'd2000};
      for (int i = 0; i < NUM_PROTO; i++) write_prototype(i, same);
      write_prototype(3, {2'd1, 16'd4000, 16'd3000, 16'd2000});
      settings_used++;
      add_row(0, 0, 0, 0, 0, 11, 1, 2'd2, CONF_LO);
      add_row('1, '1, '1, '1, '1, 12, 1, 2'd2, CONF_LO);
      add_row(12800, 0, 0, 65536 + 18000, 65536 + 28000, 13, 1, 2'd2, CONF_LO);
      run_table();
      drain();

      // Extreme register contents.
      for (int i = 0; i < NUM_PROTO; i++) write_prototype(i, '1);
      write_prototype(0, '0);
      settings_used++;
      add_row(0, 0, 0, 0, 0, 14, 1, 2'd0, CONF_HI);
      add_row('1, '1, '1, '1, '1, 15, 0, 0, 0);
      run_table();

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: for (int i = 0; i < NUM_PROTO; i++) write_prototype(i, PROTO_RESET[i]);
            PHASES - 1: for (int i = 0; i < NUM_PROTO; i++) write_prototype(i, '1);
            default: for (int i = 0; i < NUM_PROTO; i++) write_prototype(i, random_prototype());
         endcase
         settings_used++;
         idle_enable = (ph % 3) != 1;
         for (int n = 0; n < RAND_WORDS / PHASES; n++) begin
            w = random_window();
            send_window(w, classify_window(w));
         end
      end
      idle_enable = 1'b0;
      drain();

      $display("Sent %0d feature windows over %0d prototype settings, %0d result words checked.",
               words_sent, settings_used, words_checked);
      $display("Covered ties, saturated features, extreme prototypes and random idling.");
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/npc_pkg.sv
rtl/npc_feature.sv
rtl/npc_proto_cell.sv
rtl/npc_div_cell.sv
rtl/nearest_prototype_classifier_unit.sv
sim/nearest_prototype_classifier_unit_tb.sv
